// ===== src/arx_pkg.sv =====
// ----------------------------------------------------------------------------
// arx_pkg
// Shared types and constants for the ARX plant step block: payload structs,
// configuration register map, sequencer states and arithmetic widths.
// ----------------------------------------------------------------------------
package arx_pkg;

	localparam int SAMPLE_W  = 32;
	localparam int COEF_W    = 20;
	localparam int COEFN_W   = COEF_W + 1;
	localparam int PROD_W    = SAMPLE_W + COEFN_W;
	localparam int FRAC_W    = 16;
	localparam int COEF_REGS = 3;
	localparam int CFG_IDX_W = 3;
	localparam int DEAD_W    = 4;

	localparam logic signed [SAMPLE_W-1:0] Y_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SAMPLE_W-1:0] Y_MIN = 32'sh8000_0000;

	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [COEFN_W-1:0]  coefn_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_A_COEF_1 = 3'd0,
		CFG_A_COEF_2 = 3'd1,
		CFG_A_COEF_3 = 3'd2,
		CFG_B_COEF_0 = 3'd3,
		CFG_B_COEF_1 = 3'd4,
		CFG_B_COEF_2 = 3'd5,
		CFG_DEAD     = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		coef_t [COEF_REGS-1:0] a_coef;
		coef_t [COEF_REGS-1:0] b_coef;
		logic  [DEAD_W-1:0]    dead_time;
	} cfg_t;

	typedef struct packed {
		sample_t control_sample;
		sample_t disturbance;
	} in_item_t;

	typedef struct packed {
		sample_t plant_output;
		logic    saturated;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic issue;
		logic commit;
	} ctl_t;

endpackage

// ===== src/arx_ctrl.sv =====
// ----------------------------------------------------------------------------
// arx_ctrl
// Sequencer: takes one sample, issues one tap per cycle to the shared
// multiply-accumulate, drains its pipeline and commits the result.
// ----------------------------------------------------------------------------
module arx_ctrl import arx_pkg::*; #(
	parameter int NTAPS = 6,
	parameter int TAP_W = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             out_busy,
	output logic             in_ready,
	output ctl_t             ctl,
	output logic [TAP_W-1:0] tap
);

	state_t           state_q, state_nx;
	logic [TAP_W-1:0] tap_q, tap_nx;
	logic             drain_q, drain_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= '0;
			drain_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			tap_q   <= tap_nx;
			drain_q <= drain_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		tap_nx   = tap_q;
		drain_nx = drain_q;
		unique case (state_q)
			ST_IDLE: begin
				tap_nx   = '0;
				drain_nx = 1'b0;
				if (in_valid)
					state_nx = ST_ISSUE;
			end
			ST_ISSUE: begin
				tap_nx = tap_q + 1'b1;
				if (tap_q == TAP_W'(NTAPS - 1))
					state_nx = ST_DRAIN;
			end
			ST_DRAIN: begin
				drain_nx = ~drain_q;
				if (drain_q)
					state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (!out_busy)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		ctl.clear  = (state_q == ST_IDLE) && in_valid;
		ctl.issue  = (state_q == ST_ISSUE);
		ctl.commit = (state_q == ST_DONE) && !out_busy;
		tap        = tap_q;
	end

endmodule

// ===== src/arx_hist.sv =====
// ----------------------------------------------------------------------------
// arx_hist
// Sample histories and operand fetch: circular input history with valid
// bits, shifting output history, per-tap coefficient select.
// ----------------------------------------------------------------------------
module arx_hist import arx_pkg::*; #(
	parameter int INPUT_ORDER    = 3,
	parameter int FEEDBACK_ORDER = 3,
	parameter int MAX_DEAD_TIME  = 8,
	parameter int TAP_W          = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl,
	input  logic [TAP_W-1:0] tap,
	input  cfg_t             cfg,
	input  sample_t          wr_sample,
	input  sample_t          push_sample,
	output coefn_t           coef_s1,
	output sample_t          operand_s1,
	output logic             op_vld_s1
);

	localparam int DEPTH = INPUT_ORDER + MAX_DEAD_TIME;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OFF_W = $clog2(DEPTH + 1);
	localparam int FB_W  = (FEEDBACK_ORDER > 1) ? $clog2(FEEDBACK_ORDER) : 1;

	sample_t             mem [DEPTH];
	logic [DEPTH-1:0]    valid_q;
	logic [PTR_W-1:0]    head_q, head_nx, rd_addr;
	sample_t             out_hist_q [FEEDBACK_ORDER];

	logic [OFF_W-1:0]    dly, offset, head_ext;
	logic                is_out;
	logic [TAP_W-1:0]    fb_idx, reg_idx;
	logic                in_regs;
	coef_t               raw;
	coefn_t              raw_ext, coef_nx;

	sample_t             mem_data_s1, hist_s1;
	logic                mem_vld_s1, sel_out_s1;

	assign head_nx  = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_ext = OFF_W'(head_q);
	assign dly      = (32'(cfg.dead_time) > MAX_DEAD_TIME) ? OFF_W'(MAX_DEAD_TIME)
	                                                        : OFF_W'(cfg.dead_time);
	assign offset   = OFF_W'(tap) + dly;
	assign rd_addr  = (head_ext >= offset) ? PTR_W'(head_ext - offset)
	                                       : PTR_W'(head_ext + OFF_W'(DEPTH) - offset);

	assign is_out  = (32'(tap) >= INPUT_ORDER);
	assign fb_idx  = tap - TAP_W'(INPUT_ORDER);
	assign reg_idx = is_out ? fb_idx : tap;
	assign in_regs = (32'(reg_idx) < COEF_REGS);

	always_comb begin
		raw = '0;
		if (in_regs)
			raw = is_out ? cfg.a_coef[reg_idx[1:0]] : cfg.b_coef[reg_idx[1:0]];
		raw_ext = {raw[COEF_W-1], raw};
		coef_nx = is_out ? -raw_ext : raw_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			valid_q <= '0;
		end else if (ctl.clear) begin
			head_q           <= head_nx;
			valid_q[head_nx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear)
			mem[head_nx] <= wr_sample;
	end

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			mem_data_s1 <= mem[rd_addr];
			mem_vld_s1  <= valid_q[rd_addr];
			hist_s1     <= out_hist_q[fb_idx[FB_W-1:0]];
			sel_out_s1  <= is_out;
			coef_s1     <= coef_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			op_vld_s1 <= 1'b0;
		else
			op_vld_s1 <= ctl.issue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FEEDBACK_ORDER; i++)
				out_hist_q[i] <= '0;
		end else if (ctl.commit) begin
			out_hist_q[0] <= push_sample;
			for (int i = 1; i < FEEDBACK_ORDER; i++)
				out_hist_q[i] <= out_hist_q[i-1];
		end
	end

	assign operand_s1 = sel_out_s1 ? hist_s1 : (mem_vld_s1 ? mem_data_s1 : '0);

endmodule

// ===== src/arx_mac.sv =====
// ----------------------------------------------------------------------------
// arx_mac
// Shared multiply-accumulate with registered product, followed by the
// floor shift, disturbance add and 32-bit saturation.
// ----------------------------------------------------------------------------
module arx_mac import arx_pkg::*; #(
	parameter int NTAPS = 6
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctl_t      ctl,
	input  sample_t   disturbance,
	input  coefn_t    coef_s1,
	input  sample_t   operand_s1,
	input  logic      op_vld_s1,
	output out_item_t result
);

	localparam int ACC_W = PROD_W + $clog2(NTAPS);
	localparam int SH_W  = ACC_W - FRAC_W;
	localparam int SUM_W = SH_W + 1;

	logic signed [PROD_W-1:0] prod_s2;
	logic                     prod_vld_s2;
	logic signed [ACC_W-1:0]  acc_q;
	sample_t                  dist_q;
	logic signed [SH_W-1:0]   shifted;
	logic signed [SUM_W-1:0]  sum;
	logic                     sat_hi, sat_lo;

	always_ff @(posedge clk) begin
		prod_s2 <= coef_s1 * operand_s1;
		if (ctl.clear)
			dist_q <= disturbance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s2 <= 1'b0;
			acc_q       <= '0;
		end else begin
			prod_vld_s2 <= op_vld_s1;
			if (ctl.clear)
				acc_q <= '0;
			else if (prod_vld_s2)
				acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign shifted = SH_W'(acc_q >>> FRAC_W);
	assign sum     = SUM_W'(shifted) + SUM_W'(dist_q);
	assign sat_hi  = !sum[SUM_W-1] && (|sum[SUM_W-2:SAMPLE_W-1]);
	assign sat_lo  = sum[SUM_W-1] && !(&sum[SUM_W-2:SAMPLE_W-1]);

	always_comb begin
		result.saturated = sat_hi || sat_lo;
		priority if (sat_hi)
			result.plant_output = Y_MAX;
		else if (sat_lo)
			result.plant_output = Y_MIN;
		else
			result.plant_output = sum[SAMPLE_W-1:0];
	end

endmodule

// ===== src/arx_model_step.sv =====
// ----------------------------------------------------------------------------
// arx_model_step
// ARX plant simulator, one sample per transfer, on one shared
// multiply-accumulate stepped over the input and feedback taps.
//
//   channel  direction  payload                        transfer
//   in       to block   control_sample, disturbance    in_valid & in_ready
//   out      from block plant_output, saturated        out_valid & out_ready
//   cfg      to block   cfg_index, cfg_data            cfg_valid & cfg_ready
//
// An item passes through these steps in order: take the sample, issue
// each tap in turn through the single multiplier, drain its product and
// accumulate stages, and commit the result. in_ready is low while an item
// is in flight. A result waits in the output register; commit of the next
// one holds while that register is full and out_ready is low.
// Reset clears both histories, the coefficients and the dead time.
// ----------------------------------------------------------------------------
module arx_model_step import arx_pkg::*; #(
	parameter int FEEDBACK_ORDER = 3,
	parameter int INPUT_ORDER    = 3,
	parameter int MAX_DEAD_TIME  = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data
);

	localparam int NTAPS = INPUT_ORDER + FEEDBACK_ORDER;
	localparam int TAP_W = $clog2(NTAPS + 1);

	cfg_t             cfg_q;
	ctl_t             ctl;
	logic [TAP_W-1:0] tap;
	logic             out_busy;
	coefn_t           coef_s1;
	sample_t          operand_s1;
	logic             op_vld_s1;
	out_item_t        result;
	out_item_t        out_q;
	logic             out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_A_COEF_1: cfg_q.a_coef[0] <= cfg_data;
				CFG_A_COEF_2: cfg_q.a_coef[1] <= cfg_data;
				CFG_A_COEF_3: cfg_q.a_coef[2] <= cfg_data;
				CFG_B_COEF_0: cfg_q.b_coef[0] <= cfg_data;
				CFG_B_COEF_1: cfg_q.b_coef[1] <= cfg_data;
				CFG_B_COEF_2: cfg_q.b_coef[2] <= cfg_data;
				CFG_DEAD:     cfg_q.dead_time <= cfg_data[DEAD_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_busy = out_valid_q && !out_ready;

	arx_ctrl #(
		.NTAPS (NTAPS),
		.TAP_W (TAP_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_busy (out_busy),
		.in_ready (in_ready),
		.ctl      (ctl),
		.tap      (tap)
	);

	arx_hist #(
		.INPUT_ORDER    (INPUT_ORDER),
		.FEEDBACK_ORDER (FEEDBACK_ORDER),
		.MAX_DEAD_TIME  (MAX_DEAD_TIME),
		.TAP_W          (TAP_W)
	) u_hist (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.tap         (tap),
		.cfg         (cfg_q),
		.wr_sample   (in_data.control_sample),
		.push_sample (result.plant_output),
		.coef_s1     (coef_s1),
		.operand_s1  (operand_s1),
		.op_vld_s1   (op_vld_s1)
	);

	arx_mac #(
		.NTAPS (NTAPS)
	) u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.disturbance (in_data.disturbance),
		.coef_s1     (coef_s1),
		.operand_s1  (operand_s1),
		.op_vld_s1   (op_vld_s1),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.commit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.commit)
			out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_commit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> !in_ready)
		else $error("commit while sequencer idle");

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after an input transfer");

	a_out_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl.commit))
		else $error("output valid without commit");

	a_issue_no_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.issue |-> !ctl.clear && !ctl.commit)
		else $error("tap issue overlaps clear or commit");
`endif

endmodule
